// ===== design/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared constants, codes and record types of the multimode stream scheduler.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int MAX_STREAMS = 16;
    localparam int TIME_BITS   = 32;
    localparam int PRIO_BITS   = 8;
    localparam int IDX_W       = $clog2(MAX_STREAMS);
    localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
    localparam int CFG_DATA_W  = 5;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SCHED = 2'd1,
        OP_CHUNK = 2'd2,
        OP_NEXT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_RR     = 2'd0,
        MODE_RR_PKT = 2'd1,
        MODE_PRIO   = 2'd2,
        MODE_FCFS   = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_MODE   = 1'b0,
        CFG_ACTIVE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                 has_data;
        logic                 skip;
        logic [TIME_BITS-1:0] head_time;
        logic [PRIO_BITS-1:0] prio;
    } t_rec;

    typedef struct packed {
        logic             vld;
        logic             clear;
        logic             use_rr;
        logic             use_time;
        logic [IDX_W-1:0] pos;
    } t_pick_ctl;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] sid;
    } t_pick_res;

endpackage

// ===== design/ssm_ram.sv =====
// ----------------------------------------------------------------------------
// ssm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/ssm_pick.sv =====
// ----------------------------------------------------------------------------
// ssm_pick
// Candidate evaluator: folds one record per cycle into the running choice.
// ----------------------------------------------------------------------------
module ssm_pick (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssm_pkg::t_pick_ctl i_ctl,
    input  ssm_pkg::t_rec      i_rec,
    output ssm_pkg::t_pick_res o_res
);
    import ssm_pkg::*;

    logic                 r_found;
    logic [IDX_W-1:0]     r_sid;
    logic [TIME_BITS-1:0] r_time;
    logic [PRIO_BITS-1:0] r_prio;
    logic                 cand;
    logic                 better;
    logic                 upd;

    always_comb begin
        cand   = i_rec.has_data & ~(i_ctl.use_rr & i_rec.skip);
        better = ~r_found | (i_ctl.use_time ? (i_rec.head_time < r_time)
                                            : (i_rec.prio < r_prio));
        upd    = i_ctl.vld & cand & (i_ctl.use_rr ? ~r_found : better);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found <= 1'b0;
            r_sid   <= '0;
            r_time  <= '0;
            r_prio  <= '0;
        end else if (upd) begin
            r_found <= 1'b1;
            r_sid   <= i_ctl.pos;
            r_time  <= i_rec.head_time;
            r_prio  <= i_rec.prio;
        end
    end

    assign o_res.found = r_found;
    assign o_res.sid   = r_sid;

endmodule

// ===== design/stream_scheduler_multimode_unit.sv =====
// ----------------------------------------------------------------------------
// stream_scheduler_multimode_unit
// Multimode outbound stream scheduler: records live in a RAM, a sequencer
// reads them back one per cycle for round robin, priority or FCFS choice.
// ----------------------------------------------------------------------------
//  channel   signals                                   transfer when
//  in        i_in_valid / o_in_stall, payload i_*      valid & !stall
//  out       o_out_valid / i_out_stall, o_found ...    valid & !stall
//  cfg       i_cfg_valid / o_cfg_ready, index, data    valid & ready
//
//  Record writes and flag events are taken while idle, with no stall. A
//  schedule request stalls the input through last-stream read, m + 1 cursor
//  steps (m in 0..15 reductions of the last stream modulo the active count),
//  decide, n record reads (endpoint + 1 for a first priority or FCFS pass),
//  drain, pick and result. Reuse decisions skip scan, drain and pick.
//  No clearing pass after reset: per-entry valid bits stand for the zero
//  records. A held result does not block the input; a new request waits only
//  at its result step.
// ----------------------------------------------------------------------------
module stream_scheduler_multimode_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [ssm_pkg::IDX_W-1:0]     i_stream_index,
    input  logic                          i_stream_has_data,
    input  logic                          i_stream_skip,
    input  logic [ssm_pkg::TIME_BITS-1:0] i_head_time,
    input  logic [ssm_pkg::PRIO_BITS-1:0] i_stream_priority,
    input  logic                          i_peek_only,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [ssm_pkg::IDX_W-1:0]     o_chosen_stream,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_MOD,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_FIN,
        S_RESULT
    } t_state;

    t_state               r_state;
    t_mode                r_mode;
    logic [CNT_W-1:0]     r_n;
    logic [MAX_STREAMS-1:0] r_valid;
    logic [IDX_W-1:0]     r_last;
    logic                 r_next;
    logic                 r_chunk;
    logic                 r_peek;
    logic                 r_last_hd;
    logic [IDX_W-1:0]     r_endp;
    logic [IDX_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_pos;
    logic                 r_use_rr;
    logic                 r_use_time;
    logic                 r_clear;
    logic                 r_res_found;
    logic [IDX_W-1:0]     r_res_sid;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [IDX_W-1:0]     r_out_sid;

    logic [IDX_W-1:0]     n_pos;
    logic                 in_xfer;
    logic                 cfg_xfer;
    logic                 idx_ok;
    t_op                  op;
    logic                 wr_en;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    t_rec                 wr_rec;
    t_rec                 rd_rec;
    t_rec                 rec_eff;
    t_pick_ctl            pick_ctl;
    t_pick_res            pick_res;
    logic                 out_free;
    logic [CNT_W-1:0]     cfg_n;

    assign in_xfer  = i_in_valid & ~o_in_stall;
    assign cfg_xfer = i_cfg_valid & o_cfg_ready;
    assign op       = t_op'(i_opcode);
    assign idx_ok   = ({1'b0, i_stream_index} < CNT_W'(MAX_STREAMS));
    assign out_free = ~r_out_valid | ~i_out_stall;

    always_comb begin
        if ({1'b0, r_pos} + CNT_W'(1) == r_n) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + IDX_W'(1);
        end
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_n = CNT_W'(1);
        end else if (i_cfg_data > CFG_DATA_W'(MAX_STREAMS)) begin
            cfg_n = CNT_W'(MAX_STREAMS);
        end else begin
            cfg_n = CNT_W'(i_cfg_data);
        end
    end

    assign wr_en = in_xfer & (op == OP_WRITE) & idx_ok;
    assign wr_rec.has_data  = i_stream_has_data;
    assign wr_rec.skip      = i_stream_skip;
    assign wr_rec.head_time = i_head_time;
    assign wr_rec.prio      = i_stream_priority;

    assign rd_en   = (in_xfer & (op == OP_SCHED)) | (r_state == S_SCAN);
    assign rd_addr = (r_state == S_SCAN) ? n_pos : r_last;

    ssm_ram #(
        .WIDTH($bits(t_rec)),
        .DEPTH(MAX_STREAMS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_stream_index),
        .i_wr_data (wr_rec),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_rec)
    );

    // unwritten entries read as the zero record
    always_comb begin
        rec_eff = rd_rec;
        if (!r_valid[r_rd_pos]) begin
            rec_eff = '0;
        end
    end

    assign pick_ctl.vld      = r_rd_vld;
    assign pick_ctl.clear    = r_clear;
    assign pick_ctl.use_rr   = r_use_rr;
    assign pick_ctl.use_time = r_use_time;
    assign pick_ctl.pos      = r_rd_pos;

    ssm_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pick_ctl),
        .i_rec   (rec_eff),
        .o_res   (pick_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_RR;
            r_n         <= CNT_W'(MAX_STREAMS);
            r_valid     <= '0;
            r_last      <= '0;
            r_next      <= 1'b0;
            r_chunk     <= 1'b0;
            r_peek      <= 1'b0;
            r_last_hd   <= 1'b0;
            r_endp      <= '0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_pos    <= '0;
            r_use_rr    <= 1'b0;
            r_use_time  <= 1'b0;
            r_clear     <= 1'b0;
            r_res_found <= 1'b0;
            r_res_sid   <= '0;
            r_out_valid <= 1'b0;
            r_out_found <= 1'b0;
            r_out_sid   <= '0;
        end else begin
            r_clear  <= (r_state == S_DECIDE);
            r_rd_vld <= (r_state == S_SCAN);
            r_rd_pos <= (r_state == S_SCAN) ? n_pos : r_last;

            if (cfg_xfer) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MODE:   r_mode <= t_mode'(i_cfg_data[1:0]);
                    CFG_ACTIVE: r_n    <= cfg_n;
                endcase
            end

            if (o_out_valid && !i_out_stall && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (op)
                            OP_WRITE: begin
                                if (idx_ok) begin
                                    r_valid[i_stream_index] <= 1'b1;
                                end
                            end
                            OP_SCHED: begin
                                r_peek  <= i_peek_only;
                                r_endp  <= r_last;
                                r_state <= S_LAST;
                            end
                            OP_CHUNK: r_chunk <= 1'b1;
                            OP_NEXT:  r_next  <= 1'b1;
                        endcase
                    end
                end
                S_LAST: begin
                    r_last_hd <= r_valid[r_last] & rd_rec.has_data;
                    r_state   <= S_MOD;
                end
                S_MOD: begin
                    if ({1'b0, r_endp} >= r_n) begin
                        r_endp <= IDX_W'({1'b0, r_endp} - r_n);
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    unique case (r_mode)
                        MODE_RR: begin
                            if (!(r_chunk && r_next) && r_last_hd) begin
                                r_res_found <= 1'b1;
                                r_res_sid   <= r_last;
                                r_next      <= 1'b1;
                                if (!r_peek) begin
                                    r_chunk <= 1'b0;
                                end
                                r_state <= S_RESULT;
                            end else begin
                                r_use_rr   <= 1'b1;
                                r_use_time <= 1'b0;
                                r_pos      <= r_endp;
                                r_cnt      <= r_n;
                                r_state    <= S_SCAN;
                            end
                        end
                        MODE_RR_PKT: begin
                            if (r_next) begin
                                r_use_rr   <= 1'b1;
                                r_use_time <= 1'b0;
                                r_pos      <= r_endp;
                                r_cnt      <= r_n;
                                r_state    <= S_SCAN;
                            end else begin
                                r_res_found <= r_last_hd;
                                r_res_sid   <= r_last_hd ? r_last : '0;
                                if (r_last_hd && !r_peek) begin
                                    r_next <= 1'b0;
                                end
                                r_state <= S_RESULT;
                            end
                        end
                        MODE_PRIO, MODE_FCFS: begin
                            if (r_mode == MODE_PRIO && !r_chunk && r_next && r_last_hd) begin
                                r_res_found <= 1'b1;
                                r_res_sid   <= r_last;
                                r_state     <= S_RESULT;
                            end else begin
                                r_use_rr   <= 1'b0;
                                r_use_time <= (r_mode == MODE_FCFS);
                                if (!r_next) begin
                                    r_pos  <= IDX_W'(r_n - CNT_W'(1));
                                    r_cnt  <= CNT_W'({1'b0, r_endp} + CNT_W'(1));
                                    r_next <= 1'b1;
                                end else begin
                                    r_pos <= r_endp;
                                    r_cnt <= r_n;
                                end
                                r_state <= S_SCAN;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    r_pos <= n_pos;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res_found <= pick_res.found;
                    r_res_sid   <= pick_res.sid;
                    if (pick_res.found && !r_peek) begin
                        r_last <= pick_res.sid;
                        unique case (r_mode)
                            MODE_RR:     r_chunk <= 1'b0;
                            MODE_RR_PKT: r_next  <= 1'b0;
                            MODE_PRIO:   r_chunk <= 1'b0;
                            MODE_FCFS:   ;
                        endcase
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_res_found;
                        r_out_sid   <= r_res_sid;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out_found;
    assign o_chosen_stream = r_out_sid;
    assign o_cfg_ready     = 1'b1;

endmodule
